@@ rtl/tios_pkg.sv @@
// ----------------------------------------------------------------------------
// tios_pkg
// Shared types, codes and defaults of the table index search block.
// ----------------------------------------------------------------------------
package tios_pkg;

    localparam int TABLE_DEPTH = 256;

    localparam int LEN_W   = 9;
    localparam int MODE_W  = 2;
    localparam int ENTRY_W = 8;
    localparam int KEY_W   = 64;
    localparam int CFG_W   = 9;

    // request codes
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // search modes; every other code means membership only
    localparam logic [MODE_W-1:0] MODE_FIRST  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LAST   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_MEMBER = 2'd2;

    // configuration register indexes
    localparam logic CFG_LENGTH = 1'b0;
    localparam logic CFG_MODE   = 1'b1;

    typedef struct packed {
        logic               req_type;
        logic [ENTRY_W-1:0] entry_index;
        logic [KEY_W-1:0]   key_value;
    } t_item;

    typedef struct packed {
        logic [LEN_W-1:0] result_index;
        logic             found;
    } t_result;

    typedef struct packed {
        logic [LEN_W-1:0]  table_length;
        logic [MODE_W-1:0] search_mode;
    } t_cfg;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

@@ rtl/tios_ram.sv @@
// ----------------------------------------------------------------------------
// tios_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tios_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/tios_scan.sv @@
// ----------------------------------------------------------------------------
// tios_scan
// Scan sequencer: walks the table one read a cycle and compares each entry.
// ----------------------------------------------------------------------------
module tios_scan #(
    parameter int TABLE_DEPTH = tios_pkg::TABLE_DEPTH,
    localparam int AW         = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_go,
    input  logic [tios_pkg::KEY_W-1:0]   i_key,
    input  tios_pkg::t_cfg               i_cfg,
    output logic [AW-1:0]                o_raddr,
    input  logic [tios_pkg::KEY_W-1:0]   i_rdata,
    output logic                         o_busy,
    output logic                         o_done,
    output tios_pkg::t_result            o_result
);

    tios_pkg::t_state r_state, n_state;
    logic [tios_pkg::LEN_W-1:0] r_rd_idx, n_rd_idx;
    logic [tios_pkg::LEN_W-1:0] r_left, n_left;
    logic [tios_pkg::LEN_W-1:0] r_cmp_idx, n_cmp_idx;
    logic                       r_pend, n_pend;
    logic [tios_pkg::KEY_W-1:0] r_key, n_key;
    logic                       r_done, n_done;
    tios_pkg::t_result          r_result, n_result;

    logic is_last;
    logic is_member;
    logic hit;

    assign is_last   = (i_cfg.search_mode == tios_pkg::MODE_LAST);
    assign is_member = (i_cfg.search_mode != tios_pkg::MODE_FIRST) && !is_last;
    assign hit       = r_pend && (i_rdata == r_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= tios_pkg::ST_IDLE;
            r_left   <= '0;
            r_pend   <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_left   <= n_left;
            r_pend   <= n_pend;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx  <= n_rd_idx;
        r_cmp_idx <= n_cmp_idx;
        r_key     <= n_key;
        r_result  <= n_result;
    end

    always_comb begin
        n_state   = r_state;
        n_rd_idx  = r_rd_idx;
        n_left    = r_left;
        n_cmp_idx = r_cmp_idx;
        n_pend    = 1'b0;
        n_key     = r_key;
        n_done    = 1'b0;
        n_result  = r_result;
        case (r_state)
            tios_pkg::ST_IDLE: begin
                if (i_go) begin
                    n_state  = tios_pkg::ST_SCAN;
                    n_key    = i_key;
                    n_left   = i_cfg.table_length;
                    n_rd_idx = is_last ? (i_cfg.table_length - 1'b1) : '0;
                end
            end
            tios_pkg::ST_SCAN: begin
                // issue the next read while entries remain
                n_pend    = (r_left != '0);
                n_cmp_idx = r_rd_idx;
                if (r_left != '0) begin
                    n_left   = r_left - 1'b1;
                    n_rd_idx = is_last ? (r_rd_idx - 1'b1) : (r_rd_idx + 1'b1);
                end
                if (hit || (!r_pend && (r_left == '0))) begin
                    n_state               = tios_pkg::ST_IDLE;
                    n_done                = 1'b1;
                    n_pend                = 1'b0;
                    n_result.found        = hit;
                    n_result.result_index = hit ? r_cmp_idx : i_cfg.table_length;
                    if (is_member) begin
                        n_result.result_index = '0;
                    end
                end
            end
            default: begin
                n_state = tios_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_raddr  = AW'(r_rd_idx);
    assign o_busy   = (r_state == tios_pkg::ST_SCAN);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ rtl/table_index_of_search_unit.sv @@
// ----------------------------------------------------------------------------
// table_index_of_search_unit
// Exact-match linear search over a table of 64-bit words held in RAM.
// ----------------------------------------------------------------------------
// A write item (req_type 0) stores key_value at entry_index; busy stays low
// and no result follows, and a write whose index is not below TABLE_DEPTH is
// dropped. A search item (req_type 1) raises busy and reads the table through
// the single RAM read port, one entry per cycle, upward from entry 0 in first
// and membership mode and downward from table_length-1 in last mode. It stops
// at the first entry that equals the key. The result strobe o_done is high for
// one cycle, the first cycle with busy low, and start may already be accepted
// in that cycle. The receiver cannot stall: take the result while o_done is
// high. On no match result_index carries table_length; in membership mode
// (search_mode 2 or 3) result_index is 0 and only found counts. Write
// table_length and search_mode only while busy is low; a length above
// TABLE_DEPTH is held at TABLE_DEPTH. Entries must be written before a search
// reaches them.
// ----------------------------------------------------------------------------
module table_index_of_search_unit #(
    parameter int TABLE_DEPTH = tios_pkg::TABLE_DEPTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  tios_pkg::t_item              i_item,
    output logic                         o_done,
    output tios_pkg::t_result            o_result,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_idx,
    input  logic [tios_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    tios_pkg::t_cfg r_cfg;
    logic           accept;
    logic           wr_en;
    logic           go;
    logic [AW-1:0]  raddr;
    logic [tios_pkg::KEY_W-1:0] rdata;

    // Hold the configuration; clamp the length to the table size.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                tios_pkg::CFG_LENGTH: begin
                    if (32'(i_cfg_data) > TABLE_DEPTH) begin
                        r_cfg.table_length <= tios_pkg::LEN_W'(TABLE_DEPTH);
                    end else begin
                        r_cfg.table_length <= i_cfg_data;
                    end
                end
                tios_pkg::CFG_MODE: begin
                    r_cfg.search_mode <= i_cfg_data[tios_pkg::MODE_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // An item enters only while no search runs.
    assign accept = start && !busy;
    assign wr_en  = accept && (i_item.req_type == tios_pkg::REQ_WRITE)
                    && (32'(i_item.entry_index) < TABLE_DEPTH);
    assign go     = accept && (i_item.req_type == tios_pkg::REQ_SEARCH);

    tios_ram #(
        .WIDTH (tios_pkg::KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_item.entry_index)),
        .i_wdata (i_item.key_value),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    tios_scan #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_key    (i_item.key_value),
        .i_cfg    (r_cfg),
        .o_raddr  (raddr),
        .i_rdata  (rdata),
        .o_busy   (busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    // A result only ends a running search.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a running search");

    // A search item always starts a scan.
    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        go |=> busy)
        else $error("search item did not start a scan");

    // A miss in first or last mode reports the table length.
    a_miss_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.found
         && ((r_cfg.search_mode == tios_pkg::MODE_FIRST)
             || (r_cfg.search_mode == tios_pkg::MODE_LAST)))
        |-> (o_result.result_index == r_cfg.table_length))
        else $error("miss result differs from table length");

    // A hit lies inside the searched range.
    a_hit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.found
         && ((r_cfg.search_mode == tios_pkg::MODE_FIRST)
             || (r_cfg.search_mode == tios_pkg::MODE_LAST)))
        |-> (o_result.result_index < r_cfg.table_length))
        else $error("hit index outside searched range");

endmodule

@@ tb/sv/table_search_checker.sv @@
// ----------------------------------------------------------------------------
// table_search_checker
// Watches the item, result and register ports of the table search unit. Keeps
// its own copy of the table and registers, predicts each search result and
// compares every strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module table_search_checker
    import tios_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_item                i_item,
    input  logic                 i_done,
    input  t_result              i_result,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    output int                   o_pending,
    output int                   o_fail_count
);

    logic [KEY_W-1:0]  table_copy [TABLE_DEPTH];
    int                length_reg;
    logic [MODE_W-1:0] mode_reg;
    t_result           expected_results [$];
    t_result           want;

    // Linear exact-match scan, first or last hit, membership zeroes the index.
    function automatic t_result predict_search(input logic [KEY_W-1:0] key);
        t_result r;
        int      hit;
        logic    hit_seen;
        hit      = length_reg;
        hit_seen = 1'b0;
        if (mode_reg == MODE_LAST) begin
            for (int i = length_reg - 1; i >= 0; i--) begin
                if (table_copy[i] == key) begin
                    hit      = i;
                    hit_seen = 1'b1;
                    break;
                end
            end
        end else begin
            for (int i = 0; i < length_reg; i++) begin
                if (table_copy[i] == key) begin
                    hit      = i;
                    hit_seen = 1'b1;
                    break;
                end
            end
        end
        if (mode_reg != MODE_FIRST && mode_reg != MODE_LAST)
            hit = 0;
        r.result_index = hit[LEN_W-1:0];
        r.found        = hit_seen;
        return r;
    endfunction

    initial begin
        o_pending    = 0;
        o_fail_count = 0;
        length_reg   = 0;
        mode_reg     = MODE_FIRST;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++)
                table_copy[i] = '0;
            length_reg = 0;
            mode_reg   = MODE_FIRST;
            expected_results.delete();
        end else begin
            // results first: a new item may be taken in the strobe cycle
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: index %0d found %0b",
                           i_result.result_index, i_result.found);
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_result.result_index !== want.result_index) begin
                        $error("result_index: expected %0d, actual %0d",
                               want.result_index, i_result.result_index);
                        o_fail_count++;
                    end
                    if (i_result.found !== want.found) begin
                        $error("found: expected %0b, actual %0b",
                               want.found, i_result.found);
                        o_fail_count++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                if (i_item.req_type == REQ_WRITE)
                    table_copy[i_item.entry_index] = i_item.key_value;
                else
                    expected_results.push_back(predict_search(i_item.key_value));
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_LENGTH)
                    length_reg = (i_cfg_data > TABLE_DEPTH) ? TABLE_DEPTH
                                                            : int'(i_cfg_data);
                else
                    mode_reg = i_cfg_data[MODE_W-1:0];
            end
        end
        o_pending = expected_results.size();
    end

endmodule

@@ tb/sv/table_index_of_search_unit_test.sv @@
// ----------------------------------------------------------------------------
// table_index_of_search_unit_test
// Drives write and search items into the table search unit through several
// register settings and idle patterns; the checker beside the block predicts
// and compares every result, and this module gives the verdict.
// ----------------------------------------------------------------------------
module table_index_of_search_unit_test;
    import tios_pkg::*;

    localparam int PHASES        = 8;
    localparam int PHASE_ITEMS   = 115;
    localparam int POOL_SIZE     = 8;

    // unused mode code, behaves as membership
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    t_item              i_item;
    logic               o_done;
    t_result            o_result;
    logic               i_cfg_we;
    logic               i_cfg_idx;
    logic [CFG_W-1:0]   i_cfg_data;

    int                 pending;
    int                 fail_count;

    // stimulus-side bookkeeping: what each entry holds, the searched length
    logic [KEY_W-1:0]   shadow_key [TABLE_DEPTH];
    logic [KEY_W-1:0]   key_pool [POOL_SIZE];
    int                 cur_len;
    int                 idle_pct;

    table_index_of_search_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_item     (i_item),
        .o_done     (o_done),
        .o_result   (o_result),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    table_search_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_item       (i_item),
        .i_done       (o_done),
        .i_result     (o_result),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom(), $urandom()};
    endfunction

    // Present one item: idle first at the phase rate, then hold start until
    // an edge with busy low takes it. Return on the following falling edge.
    task automatic send_item(input logic req, input logic [ENTRY_W-1:0] idx,
                             input logic [KEY_W-1:0] key);
        while ($urandom_range(99) < idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start              = 1'b1;
        i_item.req_type    = req;
        i_item.entry_index = idx;
        i_item.key_value   = key;
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        if (req == REQ_WRITE)
            shadow_key[idx] = key;
    endtask

    // Drop start and wait until every expected result is in and the block is
    // idle, then let a trailing write settle.
    task automatic drain();
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
        i_cfg_idx  = idx;
        i_cfg_data = data;
        i_cfg_we   = 1'b1;
        @(negedge i_clk);
        i_cfg_we   = 1'b0;
        if (idx == CFG_LENGTH)
            cur_len = (data > TABLE_DEPTH) ? TABLE_DEPTH : int'(data);
    endtask

    task automatic set_regs(input logic [CFG_W-1:0] len,
                            input logic [MODE_W-1:0] mode);
        drain();
        write_reg(CFG_LENGTH, len);
        write_reg(CFG_MODE, CFG_W'(mode));
    endtask

    // Random traffic: writes keep reshaping the table with pooled keys so that
    // duplicates exist; searches mostly hit an entry inside the searched range.
    task automatic random_items(input int count);
        logic [KEY_W-1:0] key;
        int               pick;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(99) < 40) begin
                key = ($urandom_range(3) == 0) ? random_key()
                                               : key_pool[$urandom_range(POOL_SIZE-1)];
                send_item(REQ_WRITE, ENTRY_W'($urandom_range(TABLE_DEPTH-1)), key);
            end else begin
                pick = $urandom_range(3);
                if (pick <= 1)
                    key = shadow_key[$urandom_range(cur_len == 0 ? 0 : cur_len - 1)];
                else if (pick == 2)
                    key = key_pool[$urandom_range(POOL_SIZE-1)];
                else
                    key = random_key();
                send_item(REQ_SEARCH, ENTRY_W'($urandom()), key);
            end
        end
    endtask

    // Per-phase register setting and sender idle rate.
    int                 phase_len  [PHASES];
    logic [MODE_W-1:0]  phase_mode [PHASES];
    int                 phase_idle [PHASES];

    initial begin
        i_clk      = 1'b0;
        i_rst_n    = 1'b0;
        start      = 1'b0;
        i_item     = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = CFG_LENGTH;
        i_cfg_data = '0;
        cur_len    = 0;
        idle_pct   = 0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++)
            key_pool[i] = random_key();

        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Preload every entry so that no search ever reads an unwritten one.
        for (int i = 0; i < TABLE_DEPTH; i++)
            send_item(REQ_WRITE, ENTRY_W'(i),
                      ($urandom_range(3) == 0) ? random_key()
                                               : key_pool[$urandom_range(POOL_SIZE-1)]);

        // Directed: zero length at reset settings, then boundary entries.
        send_item(REQ_SEARCH, '0, '0);
        send_item(REQ_WRITE, 8'd0, '0);
        send_item(REQ_WRITE, 8'd255, '1);
        send_item(REQ_WRITE, 8'd100, '0);
        send_item(REQ_WRITE, 8'd200, '1);

        // full table, first match
        set_regs(9'd256, MODE_FIRST);
        send_item(REQ_SEARCH, '1, '0);
        send_item(REQ_SEARCH, '0, '1);
        send_item(REQ_SEARCH, '0, random_key());

        // last match: all-ones sits in the top entry
        set_regs(9'd256, MODE_LAST);
        send_item(REQ_SEARCH, '0, '0);
        send_item(REQ_SEARCH, '0, '1);
        send_item(REQ_SEARCH, '0, random_key());

        // membership, then the unused mode code that acts as membership
        set_regs(9'd256, MODE_MEMBER);
        send_item(REQ_SEARCH, '0, '0);
        send_item(REQ_SEARCH, '0, random_key());
        set_regs(9'd256, MODE_SPARE);
        send_item(REQ_SEARCH, '0, '1);
        send_item(REQ_SEARCH, '0, random_key());

        // lengths above the table depth hold at the depth
        set_regs(9'd511, MODE_FIRST);
        send_item(REQ_SEARCH, '0, random_key());
        send_item(REQ_SEARCH, '0, '1);
        set_regs(9'd257, MODE_LAST);
        send_item(REQ_SEARCH, '0, '0);

        // single entry: a hit on it and a miss returning the length
        set_regs(9'd1, MODE_FIRST);
        send_item(REQ_SEARCH, '0, '0);
        send_item(REQ_SEARCH, '0, '1);

        // Random phases: settings sweep small and full lengths, all modes,
        // and sender idle rates of none, 75 and 15 percent.
        phase_len[0] = 16;                      phase_mode[0] = MODE_FIRST;
        phase_len[1] = 256;                     phase_mode[1] = MODE_LAST;
        phase_len[2] = 511;                     phase_mode[2] = MODE_MEMBER;
        phase_len[3] = 1;                       phase_mode[3] = MODE_SPARE;
        phase_len[4] = 0;                       phase_mode[4] = MODE_LAST;
        phase_len[5] = $urandom_range(40, 2);   phase_mode[5] = MODE_LAST;
        phase_len[6] = $urandom_range(510, 257); phase_mode[6] = MODE_FIRST;
        phase_len[7] = $urandom_range(64, 1);   phase_mode[7] = MODE_FIRST;
        for (int p = 0; p < PHASES; p++)
            phase_idle[p] = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 75 : 15);

        for (int p = 0; p < PHASES; p++) begin
            set_regs(CFG_W'(phase_len[p]), phase_mode[p]);
            idle_pct = phase_idle[p];
            random_items(PHASE_ITEMS);
        end

        // Drain, then watch a full scan's worth of cycles for stray results.
        idle_pct = 0;
        drain();
        repeat (TABLE_DEPTH + 8) @(negedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // Hard stop well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
